[rtl/ckb_pkg.sv]
// ----------------------------------------------------------------------------
// ckb_pkg
// Shared types and constants of the color keyed image blit core.
// ----------------------------------------------------------------------------
package ckb_pkg;

	// register indexes of the configuration port
	localparam logic [2:0] REG_SCREEN_WIDTH  = 3'd0;
	localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd1;
	localparam logic [2:0] REG_LINE_STRIDE   = 3'd2;
	localparam logic [2:0] REG_DEST_X        = 3'd3;
	localparam logic [2:0] REG_DEST_Y        = 3'd4;
	localparam logic [2:0] REG_IMAGE_WIDTH   = 3'd5;
	localparam logic [2:0] REG_IMAGE_HEIGHT  = 3'd6;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// field widths
	localparam int DIM_W   = 13;
	localparam int PITCH_W = 14;
	localparam int POS_W   = 16;
	localparam int COL_W   = 12;
	localparam int ROW_W   = 13;
	localparam int COLOR_W = 32;
	localparam int ADDR_W  = 25;
	localparam int PROD_W  = DIM_W + PITCH_W;

	// largest image dimension, larger values are clamped to it
	localparam logic [DIM_W-1:0] MAX_DIM = 13'd4096;

	// transparent color
	localparam logic [COLOR_W-1:0] KEY_COLOR = 32'h00FF_00FF;

	// queue between front and back
	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);
	localparam int QCW    = $clog2(QDEPTH + 1);

	// configuration register set
	typedef struct packed {
		logic [DIM_W-1:0]   screen_width;
		logic [DIM_W-1:0]   screen_height;
		logic [PITCH_W-1:0] line_stride;
		logic [POS_W-1:0]   dest_x;
		logic [POS_W-1:0]   dest_y;
		logic [DIM_W-1:0]   image_width;
		logic [DIM_W-1:0]   image_height;
	} cfg_t;

	// one visible pixel, already clipped, waiting for its address
	typedef struct packed {
		logic [DIM_W-1:0]   row_pos;
		logic [DIM_W-1:0]   col_pos;
		logic [COLOR_W-1:0] color;
	} entry_t;

	// clamp an image dimension to the largest one supported
	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
		return (v > MAX_DIM) ? MAX_DIM : v;
	endfunction

endpackage

[rtl/ckb_front.sv]
// ----------------------------------------------------------------------------
// ckb_front
// Tracks the pixel position in the image, clips it to the screen and drops
// keyed pixels; visible pixels go into the queue.
// ----------------------------------------------------------------------------
module ckb_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ckb_pkg::cfg_t                 cfg,
	input  logic                          accept,
	input  logic [ckb_pkg::COLOR_W-1:0]   pixel_color,
	input  logic                          first_pixel,
	output logic                          entry_valid,
	output ckb_pkg::entry_t               entry
);

	logic [ckb_pkg::COL_W-1:0] col_q;
	logic [ckb_pkg::ROW_W-1:0] row_q;

	logic [ckb_pkg::DIM_W-1:0] width_eff;
	logic [ckb_pkg::DIM_W-1:0] height_eff;
	logic [ckb_pkg::COL_W-1:0] col_cur;
	logic [ckb_pkg::ROW_W-1:0] row_cur;
	logic                      in_image;
	logic signed [ckb_pkg::POS_W:0] pos_x;
	logic signed [ckb_pkg::POS_W:0] pos_y;
	logic                      inside_x;
	logic                      inside_y;
	logic                      row_end;

	// current position, a first pixel restarts at the origin
	always_comb begin
		width_eff  = ckb_pkg::clamp_dim(cfg.image_width);
		height_eff = ckb_pkg::clamp_dim(cfg.image_height);
		col_cur    = first_pixel ? '0 : col_q;
		row_cur    = first_pixel ? '0 : row_q;
		in_image   = (width_eff != '0) && (row_cur < height_eff);
		row_end    = ({1'b0, col_cur} + 13'd1) >= width_eff;
	end

	// screen position and clipping
	always_comb begin
		pos_x = $signed({cfg.dest_x[ckb_pkg::POS_W-1], cfg.dest_x})
			+ $signed({5'd0, col_cur});
		pos_y = $signed({cfg.dest_y[ckb_pkg::POS_W-1], cfg.dest_y})
			+ $signed({4'd0, row_cur});
		inside_x = !pos_x[ckb_pkg::POS_W]
			&& (pos_x[ckb_pkg::POS_W-1:0] < {3'd0, cfg.screen_width});
		inside_y = !pos_y[ckb_pkg::POS_W]
			&& (pos_y[ckb_pkg::POS_W-1:0] < {3'd0, cfg.screen_height});
	end

	// queue entry for a visible pixel
	always_comb begin
		entry_valid   = accept && in_image && inside_x && inside_y
			&& (pixel_color != ckb_pkg::KEY_COLOR);
		entry.row_pos = pos_y[ckb_pkg::DIM_W-1:0];
		entry.col_pos = pos_x[ckb_pkg::DIM_W-1:0];
		entry.color   = pixel_color;
	end

	// column and row counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (!in_image) begin
				col_q <= col_cur;
				row_q <= row_cur;
			end else if (row_end) begin
				col_q <= '0;
				row_q <= row_cur + 13'd1;
			end else begin
				col_q <= col_cur + 12'd1;
				row_q <= row_cur;
			end
		end
	end

endmodule

[rtl/ckb_queue.sv]
// ----------------------------------------------------------------------------
// ckb_queue
// Short first-in first-out queue of clipped pixels between front and back.
// ----------------------------------------------------------------------------
module ckb_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_en,
	input  ckb_pkg::entry_t wr_data,
	input  logic            rd_en,
	output ckb_pkg::entry_t rd_data,
	output logic            full,
	output logic            not_empty
);

	ckb_pkg::entry_t mem_q [ckb_pkg::QDEPTH];

	logic [ckb_pkg::QAW-1:0] wr_ptr_q;
	logic [ckb_pkg::QAW-1:0] rd_ptr_q;
	logic [ckb_pkg::QCW-1:0] count_q;

	assign full      = (count_q == ckb_pkg::QCW'(ckb_pkg::QDEPTH));
	assign not_empty = (count_q != '0);
	assign rd_data   = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[rtl/ckb_back.sv]
// ----------------------------------------------------------------------------
// ckb_back
// Turns a clipped pixel into a framebuffer write: multiplies the row by the
// pitch, then adds the column in the output register.
// ----------------------------------------------------------------------------
module ckb_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [ckb_pkg::PITCH_W-1:0] line_stride,
	input  logic                        entry_valid,
	input  ckb_pkg::entry_t             entry,
	output logic                        entry_take,
	input  logic                        pop,
	output logic                        empty,
	output logic [ckb_pkg::ADDR_W-1:0]  write_address,
	output logic [ckb_pkg::COLOR_W-1:0] write_data
);

	logic                        valid_s1;
	logic [ckb_pkg::ADDR_W-1:0]  prod_s1;
	logic [ckb_pkg::DIM_W-1:0]   col_s1;
	logic [ckb_pkg::COLOR_W-1:0] color_s1;

	logic                        valid_s2;
	logic [ckb_pkg::ADDR_W-1:0]  addr_s2;
	logic [ckb_pkg::COLOR_W-1:0] data_s2;

	logic                        load_s2;
	logic                        load_s1;
	logic [ckb_pkg::PROD_W-1:0]  product;

	// stage enables, each stage moves when the next one has room
	always_comb begin
		load_s2    = !valid_s2 || pop;
		load_s1    = !valid_s1 || load_s2;
		entry_take = load_s1 && entry_valid;
		product    = entry.row_pos * line_stride;
	end

	// stage 1: row times pitch
	always_ff @(posedge clk) begin
		if (load_s1) begin
			prod_s1  <= product[ckb_pkg::ADDR_W-1:0];
			col_s1   <= entry.col_pos;
			color_s1 <= entry.color;
		end
	end

	// stage 2: add column, result waits here until popped
	always_ff @(posedge clk) begin
		if (load_s2) begin
			addr_s2 <= prod_s1 + {{(ckb_pkg::ADDR_W - ckb_pkg::DIM_W){1'b0}}, col_s1};
			data_s2 <= color_s1;
		end
	end

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (load_s1) begin
				valid_s1 <= entry_valid;
			end
			if (load_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	assign empty         = !valid_s2;
	assign write_address = addr_s2;
	assign write_data    = data_s2;

endmodule

[rtl/color_keyed_image_blit_core.sv]
// ----------------------------------------------------------------------------
// color_keyed_image_blit_core
// Color keyed sprite blit with clipping: one source pixel in, at most one
// framebuffer word write out.
// ----------------------------------------------------------------------------
// Source pixels are pushed in row-major order, one per cycle; first_pixel
// restarts the column and row counters. Each pixel placed inside the screen
// whose color is not 0x00FF00FF yields one write (address = row * line stride
// + column, modulo 2^25), all others yield nothing. The front end classifies
// a pixel in the cycle it is pushed and takes one pixel every cycle while
// full is low; a four entry queue feeds the back end, whose row-times-pitch
// multiplier and column adder form two register stages, the product and
// output registers; writes can be popped one per cycle while empty is low.
// Configuration registers are to be written only while the block is idle
// (not enforced by the block); pixels past the image height are ignored.
// ----------------------------------------------------------------------------
module color_keyed_image_blit_core (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration write port
	input  logic                           cfg_write,
	input  logic [ckb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ckb_pkg::CFG_DATA_W-1:0] cfg_data,
	// pixel input
	input  logic                           push,
	output logic                           full,
	input  logic [ckb_pkg::COLOR_W-1:0]    pixel_color,
	input  logic                           first_pixel,
	// framebuffer writes
	output logic                           empty,
	input  logic                           pop,
	output logic [ckb_pkg::ADDR_W-1:0]     write_address,
	output logic [ckb_pkg::COLOR_W-1:0]    write_data
);

	ckb_pkg::cfg_t   cfg_q;
	ckb_pkg::entry_t front_entry;
	ckb_pkg::entry_t queue_entry;

	logic accept;
	logic front_valid;
	logic queue_not_empty;
	logic queue_take;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				ckb_pkg::REG_SCREEN_WIDTH:  cfg_q.screen_width  <= cfg_data[12:0];
				ckb_pkg::REG_SCREEN_HEIGHT: cfg_q.screen_height <= cfg_data[12:0];
				ckb_pkg::REG_LINE_STRIDE:   cfg_q.line_stride   <= cfg_data[13:0];
				ckb_pkg::REG_DEST_X:        cfg_q.dest_x        <= cfg_data;
				ckb_pkg::REG_DEST_Y:        cfg_q.dest_y        <= cfg_data;
				ckb_pkg::REG_IMAGE_WIDTH:   cfg_q.image_width   <= cfg_data[12:0];
				ckb_pkg::REG_IMAGE_HEIGHT:  cfg_q.image_height  <= cfg_data[12:0];
				default:                    cfg_q               <= cfg_q;
			endcase
		end
	end

	// an item is taken whenever the queue has room
	assign accept = push && !full;

	ckb_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.accept      (accept),
		.pixel_color (pixel_color),
		.first_pixel (first_pixel),
		.entry_valid (front_valid),
		.entry       (front_entry)
	);

	ckb_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (front_valid),
		.wr_data   (front_entry),
		.rd_en     (queue_take),
		.rd_data   (queue_entry),
		.full      (full),
		.not_empty (queue_not_empty)
	);

	ckb_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.line_stride   (cfg_q.line_stride),
		.entry_valid   (queue_not_empty),
		.entry         (queue_entry),
		.entry_take    (queue_take),
		.pop           (pop),
		.empty         (empty),
		.write_address (write_address),
		.write_data    (write_data)
	);

endmodule
